### design/rpa_pkg.sv
// shared types, constants and reset tables for the palette allocator
package rpa_pkg;

	localparam int unsigned ENTRIES_DEF  = 256;
	localparam int unsigned RESERVED_DEF = 16;
	localparam int unsigned COLOR_W      = 24;
	localparam int unsigned COUNT_W      = 31;
	localparam int unsigned IDX_W        = 8;
	localparam int unsigned DIST_W       = 18;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] RESERVED_COUNT = 31'd1073741823;

	// request codes
	localparam logic [1:0] REQ_GET  = 2'd0;
	localparam logic [1:0] REQ_FREE = 2'd1;
	localparam logic [1:0] REQ_FADE = 2'd2;

	// how an entry was found
	localparam logic [1:0] HOW_BLACK   = 2'd0;
	localparam logic [1:0] HOW_MATCH   = 2'd1;
	localparam logic [1:0] HOW_NEAREST = 2'd2;
	localparam logic [1:0] HOW_FREED   = 2'd3;

	// startup colours of the reserved entries
	function automatic logic [COLOR_W-1:0] startup_color(input logic [3:0] i);
		logic [COLOR_W-1:0] c;
		case (i)
			4'd0:    c = 24'h000000;
			4'd1:    c = 24'h0000AB;
			4'd2:    c = 24'h00AB00;
			4'd3:    c = 24'h00ABAB;
			4'd4:    c = 24'hAB0000;
			4'd5:    c = 24'hAB00AB;
			4'd6:    c = 24'hAB5500;
			4'd7:    c = 24'hABABAB;
			4'd8:    c = 24'h555555;
			4'd9:    c = 24'h5555FF;
			4'd10:   c = 24'h55FF55;
			4'd11:   c = 24'h55FFFF;
			4'd12:   c = 24'hFF5555;
			4'd13:   c = 24'hFF55FF;
			4'd14:   c = 24'hFFFF55;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	// commands from controller to datapath
	typedef struct packed {
		logic load;        // capture request beat
		logic clr_start;   // start clearing pass
		logic clr_step;    // write one entry of the clearing pass
		logic rd_issue;    // read memory at scan pointer
		logic scan_start;  // reset scan pointer
		logic scan_next;   // advance scan pointer
		logic near_mode;   // scan evaluates distance instead of match
		logic fade_rd;     // read faded entry
		logic fade_apply;  // decrement faded entry, compute new colour
		logic free_apply;  // decrement entry for free
		logic pick_match;  // latch current entry as match winner
		logic pick_black;  // winner is entry 0
		logic inc_rd;      // read winner entry
		logic inc_wr;      // write back incremented winner
		logic out_load;    // load result register
	} rpa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic hit;         // current entry matches or is free
		logic is_black;
		logic [1:0] req;
	} rpa_sts_t;

endpackage

### design/refcounted_palette_allocator.sv
// top level of the reference-counted palette allocator
//  channel | signals                              | direction
//  request | valid, stall, req_type .. fade_add   | in
//  result  | out_valid, out_stall, result_index.. | out
// a free reads its entry and decrements it; a get scans entries from 1 up to the first match or free entry;
// a full miss makes a match pass and then a nearest pass, both through the single read port
// a fade reads its entry and decrements it (FREAD, FAPPLY) in front of its get
// after reset a clearing pass writes each of the ENTRIES entries in turn, stall high
// the result register holds until taken; a new request waits for that
module refcounted_palette_allocator #(
	parameter int unsigned ENTRIES          = rpa_pkg::ENTRIES_DEF,
	parameter int unsigned RESERVED_ENTRIES = rpa_pkg::RESERVED_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid,
	output logic                        stall,
	input  logic [1:0]                  req_type,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  entry_index,
	input  logic [8:0]                  fade_mul,
	input  logic [7:0]                  fade_add,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  result_index,
	output logic [rpa_pkg::COUNT_W-1:0] remaining_count,
	output logic [1:0]                  how_found
);
	import rpa_pkg::*;

	rpa_cmd_t cmd;
	rpa_sts_t sts;

	rpa_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(valid), .in_stall(stall),
		.out_valid, .out_stall,
		.req_type, .cmd, .sts
	);

	rpa_datapath #(.ENTRIES(ENTRIES), .RESERVED(RESERVED_ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.req_type, .red, .green, .blue, .entry_index, .fade_mul, .fade_add,
		.result_index, .remaining_count, .how_found
	);

	// a request beat is never taken while a result is held back
	a_no_take_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> stall) else $error("beat taken while result held");

	// a black result always names entry 0
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && how_found == HOW_BLACK) |-> (result_index == 8'd0))
		else $error("black result not entry 0");

	// a granted entry never reports a zero count
	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && how_found != HOW_FREED) |-> (remaining_count != '0))
		else $error("granted entry with zero count");

endmodule

### design/rpa_datapath.sv
// palette memories, scan pointer, distance unit and result register
module rpa_datapath #(
	parameter int unsigned ENTRIES  = rpa_pkg::ENTRIES_DEF,
	parameter int unsigned RESERVED = rpa_pkg::RESERVED_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpa_pkg::rpa_cmd_t             cmd,
	output rpa_pkg::rpa_sts_t             sts,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    entry_index,
	input  logic [8:0]                    fade_mul,
	input  logic [7:0]                    fade_add,
	output logic [7:0]                    result_index,
	output logic [rpa_pkg::COUNT_W-1:0]   remaining_count,
	output logic [1:0]                    how_found
);
	import rpa_pkg::*;

	localparam int unsigned AW = $clog2(ENTRIES);

	logic [COLOR_W-1:0] color_mem [ENTRIES];
	logic [COUNT_W-1:0] count_mem [ENTRIES];

	logic [1:0]         req_q;
	logic [COLOR_W-1:0] color_q;
	logic [7:0]         idx_q;
	logic [8:0]         mul_q;
	logic [7:0]         add_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      rd_addr_q;
	logic [COLOR_W-1:0] rd_color_q;
	logic [COUNT_W-1:0] rd_count_q;
	logic [AW-1:0]      win_q;
	logic [1:0]         how_q;
	logic [DIST_W-1:0]  best_q;
	logic               have_q;
	logic [AW:0]        clr_q;

	logic               idx_ok;
	logic [AW-1:0]      idx_a;
	logic [AW-1:0]      rd_addr;
	logic [COLOR_W-1:0] wr_color;
	logic               wr_color_en;
	logic [COUNT_W-1:0] wr_count;
	logic               wr_count_en;
	logic [AW-1:0]      wr_addr;
	logic [DIST_W-1:0]  sq_dist;
	logic [8:0]         dr, dg, db;
	logic [COLOR_W-1:0] faded;
	logic [16:0]        pr, pg, pb;
	logic [COUNT_W-1:0] dec_count;
	logic [COUNT_W-1:0] inc_count;

	assign idx_ok = (32'(idx_q) < 32'(ENTRIES));
	assign idx_a  = AW'(idx_q);

	// read address: scan pointer or captured index or winner
	always_comb begin
		if (cmd.fade_rd)
			rd_addr = idx_a;
		else if (cmd.inc_rd)
			rd_addr = win_q;
		else
			rd_addr = ptr_q;
	end

	// squared distance between request colour and read entry
	always_comb begin
		dr = {1'b0, color_q[23:16]} - {1'b0, rd_color_q[23:16]};
		dg = {1'b0, color_q[15:8]}  - {1'b0, rd_color_q[15:8]};
		db = {1'b0, color_q[7:0]}   - {1'b0, rd_color_q[7:0]};
		if (dr[8]) dr = -dr;
		if (dg[8]) dg = -dg;
		if (db[8]) db = -db;
		sq_dist = DIST_W'({8'h00, dr[7:0]} * {8'h00, dr[7:0]})
			+ DIST_W'({8'h00, dg[7:0]} * {8'h00, dg[7:0]})
			+ DIST_W'({8'h00, db[7:0]} * {8'h00, db[7:0]});
	end

	// fade arithmetic on the read colour, the fade offset alone when out of range
	always_comb begin
		pr = rd_color_q[23:16] * mul_q;
		pg = rd_color_q[15:8]  * mul_q;
		pb = rd_color_q[7:0]   * mul_q;
		faded = {pr[15:8] + add_q, pg[15:8] + add_q, pb[15:8] + add_q};
		if (!idx_ok)
			faded = {add_q, add_q, add_q};
	end

	assign dec_count = (rd_count_q != '0) ? rd_count_q - 1'b1 : rd_count_q;
	assign inc_count = (rd_count_q != COUNT_MAX) ? rd_count_q + 1'b1 : rd_count_q;

	// memory write selection
	always_comb begin
		wr_addr     = rd_addr_q;
		wr_color    = color_q;
		wr_color_en = 1'b0;
		wr_count    = inc_count;
		wr_count_en = 1'b0;
		if (cmd.clr_step) begin
			wr_addr     = clr_q[AW-1:0];
			wr_color    = (clr_q < (AW+1)'(RESERVED)) ? startup_color(clr_q[3:0]) : '0;
			wr_count    = (clr_q < (AW+1)'(RESERVED)) ? RESERVED_COUNT : '0;
			wr_color_en = 1'b1;
			wr_count_en = 1'b1;
		end else if ((cmd.fade_apply || cmd.free_apply) && idx_ok) begin
			wr_count    = dec_count;
			wr_count_en = 1'b1;
		end else if (cmd.pick_match) begin
			wr_color_en = (rd_count_q == '0);
		end else if (cmd.inc_wr) begin
			wr_count_en = 1'b1;
		end
	end

	// palette memories
	always_ff @(posedge clk) begin
		if (wr_color_en)
			color_mem[wr_addr] <= wr_color;
		if (wr_count_en)
			count_mem[wr_addr] <= wr_count;
		rd_color_q <= color_mem[rd_addr];
		rd_count_q <= count_mem[rd_addr];
	end

	// request capture, scan state and winner tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			ptr_q  <= '0;
			req_q  <= REQ_GET;
			have_q <= 1'b0;
		end else begin
			if (cmd.clr_start)
				clr_q <= '0;
			else if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.load)
				req_q <= req_type;
			if (cmd.scan_start) begin
				ptr_q  <= cmd.near_mode ? '0 : AW'(1);
				have_q <= 1'b0;
			end else if (cmd.scan_next)
				ptr_q <= ptr_q + 1'b1;
			if (cmd.near_mode && !cmd.scan_start && !cmd.rd_issue && rd_count_q != '0
				&& (!have_q || sq_dist < best_q))
				have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue || cmd.fade_rd || cmd.inc_rd)
			rd_addr_q <= rd_addr;
		if (cmd.load) begin
			color_q <= {red, green, blue};
			idx_q   <= entry_index;
			mul_q   <= fade_mul;
			add_q   <= fade_add;
		end
		if (cmd.fade_apply)
			color_q <= faded;
		if (cmd.scan_start && cmd.near_mode) begin
			win_q <= '0;
			how_q <= HOW_NEAREST;
		end
		if (cmd.near_mode && !cmd.scan_start && !cmd.rd_issue && rd_count_q != '0
			&& (!have_q || sq_dist < best_q)) begin
			win_q  <= rd_addr_q;
			best_q <= sq_dist;
		end
		if (cmd.pick_match) begin
			win_q <= rd_addr_q;
			how_q <= HOW_MATCH;
		end
		if (cmd.pick_black) begin
			win_q <= '0;
			how_q <= HOW_BLACK;
		end
		if (cmd.out_load) begin
			if (cmd.free_apply) begin
				result_index    <= idx_q;
				remaining_count <= idx_ok ? dec_count : '0;
				how_found       <= HOW_FREED;
			end else begin
				result_index    <= 8'(win_q);
				remaining_count <= inc_count;
				how_found       <= how_q;
			end
		end
	end

	assign sts.clr_last  = (clr_q == (AW+1)'(ENTRIES - 1));
	assign sts.scan_last = (ptr_q == AW'(ENTRIES - 1));
	assign sts.hit       = (rd_color_q == color_q) || (rd_count_q == '0);
	assign sts.is_black  = (color_q == '0);
	assign sts.req       = req_q;

endmodule

### design/rpa_ctrl.sv
// request sequencer for the palette allocator
module rpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        req_type,
	output rpa_pkg::rpa_cmd_t cmd,
	input  rpa_pkg::rpa_sts_t sts
);
	import rpa_pkg::*;

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_FREAD  = 12'b000000000100,
		ST_FAPPLY = 12'b000000001000,
		ST_GSTART = 12'b000000010000,
		ST_MREAD  = 12'b000000100000,
		ST_MCHK   = 12'b000001000000,
		ST_NREAD  = 12'b000010000000,
		ST_NCHK   = 12'b000100000000,
		ST_IREAD  = 12'b001000000000,
		ST_IWAIT  = 12'b010000000000,
		ST_FREE   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fire;
	logic   done;

	assign fire      = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (fire) begin
					cmd.load = 1'b1;
					case (req_type)
						REQ_GET:  state_d = ST_GSTART;
						REQ_FREE: state_d = ST_FREAD;
						REQ_FADE: state_d = ST_FREAD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_FREAD: begin
				cmd.fade_rd = 1'b1;
				state_d = ST_FAPPLY;
			end
			ST_FAPPLY: begin
				if (sts.req == REQ_FREE) begin
					cmd.free_apply = 1'b1;
					cmd.out_load   = 1'b1;
					done           = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.fade_apply = 1'b1;
					state_d = ST_GSTART;
				end
			end
			ST_GSTART: begin
				if (sts.is_black) begin
					cmd.pick_black = 1'b1;
					state_d = ST_IREAD;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_MREAD;
				end
			end
			ST_MREAD: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_MCHK;
			end
			ST_MCHK: begin
				if (sts.hit) begin
					cmd.pick_match = 1'b1;
					state_d = ST_IREAD;
				end else if (sts.scan_last) begin
					cmd.scan_start = 1'b1;
					cmd.near_mode  = 1'b1;
					state_d = ST_NREAD;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = ST_MREAD;
				end
			end
			ST_NREAD: begin
				cmd.rd_issue  = 1'b1;
				cmd.near_mode = 1'b1;
				state_d = ST_NCHK;
			end
			ST_NCHK: begin
				cmd.near_mode = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_IREAD;
				end else begin
					cmd.scan_next = 1'b1;
					state_d = ST_NREAD;
				end
			end
			ST_IREAD: begin
				cmd.inc_rd = 1'b1;
				state_d = ST_IWAIT;
			end
			ST_IWAIT: begin
				cmd.inc_wr   = 1'b1;
				cmd.out_load = 1'b1;
				done         = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_FREE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
